>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the exponentiation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition observed");

// The antecedent must be accompanied by the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`endif

>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, defaults and shared types for the exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int BASE_W            = 32;
   localparam int EXP_W             = 64;
   localparam int RESULT_W          = 32;
   localparam int MODULUS_W         = 32;
   localparam int REQ_TDATA_W       = BASE_W + EXP_W;
   localparam int RSP_TDATA_W       = RESULT_W;

   typedef struct packed {
      logic busy;
      logic done;
   } mexp_status_type;

endpackage

>>> hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// Interleaved modular multiplier
// Computes x * y mod m one bit of x per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mexp_modmul #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [OPERAND_WIDTH-1:0]   op_x,
   input  logic [OPERAND_WIDTH-1:0]   op_y,
   input  logic [OPERAND_WIDTH:0]     modulus,
   output mexp_pkg::mexp_status_type  status,
   output logic [OPERAND_WIDTH-1:0]   product
);

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     y_ff, y_in;
   logic [W:0]       m_ff, m_in;
   logic [W-1:0]     r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0]       dbl;
   logic [W:0]       dbl_red;
   logic [W+1:0]     sum;
   logic [W+1:0]     diff;
   logic [W-1:0]     step;

   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ff) ? (dbl - m_ff) : dbl;
      sum     = {1'b0, dbl_red} + {2'b00, y_ff};
      diff    = sum - {1'b0, m_ff};
      if (x_ff[W-1]) begin
         step = (sum >= {1'b0, m_ff}) ? diff[W-1:0] : sum[W-1:0];
      end else begin
         step = dbl_red[W-1:0];
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = op_x;
         y_in    = op_y;
         m_in    = modulus;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[W-2:0], 1'b0};
         r_in   = step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = r_ff;

endmodule

>>> hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises a base to a 64-bit exponent modulo a programmed modulus using
// right-to-left square-and-multiply on one shared modular multiplier.
// ----------------------------------------------------------------------------
// The csr port writes the modulus; write it only while the block is idle.
// A request transfer carries the base and the exponent. One response
// transfer follows with the base to the exponent modulo the modulus, or 1
// when the exponent is zero. A modulus of zero acts as two to the power
// OPERAND_WIDTH.
// Each modular product runs in the shared multiplier, started from the
// request transfer or from the previous product.
// An item needs one product to reduce the base, one per set exponent bit and
// one square per exponent bit below the highest set one, and the response is
// registered from the done state after the last product: with W = 32 at most
// 128 products. A zero exponent goes from idle straight to the done state.
// The block takes one item at a time; req_tready is high only while idle.
// A finished result waits in the output register while the receiver stalls,
// and a new request may be taken as soon as the result is stored there.
// Reset sets the modulus to 1 and drops all valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mexp_pkg::REQ_TDATA_W-1:0] req_tdata,  // base_value, exponent
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mexp_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // power_result
   input  logic                             csr_wr_en,
   input  logic [mexp_pkg::MODULUS_W-1:0]   csr_wr_data
);

   localparam int W     = OPERAND_WIDTH;
   localparam int EXP_W = mexp_pkg::EXP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [mexp_pkg::MODULUS_W-1:0]  modulus_ff, modulus_in;
   logic [W-1:0]                    power_ff, power_in;
   logic [W-1:0]                    acc_ff, acc_in;
   logic [EXP_W-1:0]                exp_ff, exp_in;
   logic                            start_ff, start_in;
   logic [W-1:0]                    op_x_ff, op_x_in;
   logic [W-1:0]                    op_y_ff, op_y_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mexp_pkg::RESULT_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [W-1:0]                    mod_low;
   logic [W:0]                      mod_eff;
   logic [W-1:0]                    one_mod;
   logic [W-1:0]                    base_low;
   logic [EXP_W-1:0]                exp_next;
   logic                            req_fire;
   logic                            mul_wait;
   logic [W-1:0]                    product;
   mexp_pkg::mexp_status_type       mul_status;

   assign mod_low  = modulus_ff[W-1:0];
   assign mod_eff  = (mod_low == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_low};
   assign one_mod  = (mod_eff == (W+1)'(1)) ? '0 : W'(1);
   assign base_low = req_tdata[W-1:0];
   assign exp_next = exp_ff >> 1;
   assign req_fire = req_tvalid && req_tready;
   assign mul_wait = (state_ff == ST_REDUCE) || (state_ff == ST_MUL) || (state_ff == ST_SQR);

   mexp_modmul #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .op_x    (op_x_ff),
      .op_y    (op_y_ff),
      .modulus (mod_eff),
      .status  (mul_status),
      .product (product)
   );

   always_comb begin
      state_in     = state_ff;
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      power_in     = power_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      start_in     = 1'b0;
      op_x_in      = op_x_ff;
      op_y_in      = op_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               exp_in = req_tdata[mexp_pkg::BASE_W +: EXP_W];
               if (req_tdata[mexp_pkg::BASE_W +: EXP_W] == '0) begin
                  acc_in   = W'(1);
                  state_in = ST_DONE;
               end else begin
                  start_in = 1'b1;
                  op_x_in  = base_low;
                  op_y_in  = one_mod;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               power_in = product;
               acc_in   = one_mod;
               start_in = 1'b1;
               if (exp_ff[0]) begin
                  op_x_in  = one_mod;
                  op_y_in  = product;
                  state_in = ST_MUL;
               end else begin
                  op_x_in  = product;
                  op_y_in  = product;
                  state_in = ST_SQR;
               end
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               acc_in = product;
               if (exp_next == '0) begin
                  state_in = ST_DONE;
               end else begin
                  start_in = 1'b1;
                  op_x_in  = power_ff;
                  op_y_in  = power_ff;
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_status.done) begin
               power_in = product;
               exp_in   = exp_next;
               start_in = 1'b1;
               if (exp_next[0]) begin
                  op_x_in  = acc_ff;
                  op_y_in  = product;
                  state_in = ST_MUL;
               end else begin
                  op_x_in  = product;
                  op_y_in  = product;
                  state_in = ST_SQR;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mexp_pkg::RESULT_W'(acc_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= mexp_pkg::MODULUS_W'(1);
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      power_ff    <= power_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      op_x_ff     <= op_x_in;
      op_y_ff     <= op_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The multiplier never runs while a new request can be taken.
   `ASSERT_NEVER(a_ready_while_busy, clock, reset, req_tready && (mul_status.busy || start_ff))
   // A finished product only arrives while the sequencer waits for one.
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, mul_status.done, mul_wait)
   // Multiply and square steps only run on a nonzero remaining exponent.
   `ASSERT_NEVER(a_exp_nonzero, clock, reset, (state_ff == ST_MUL || state_ff == ST_SQR) && exp_ff == '0)

endmodule

>>> bench/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Streams base and exponent pairs through the block under several modulus
// settings and checks each response transfer against its directed-row answer
// or a square-and-multiply predictor kept in the bench. A short directed table
// covers the extremes, then random traffic runs, mostly with random stalls on both sides.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

   localparam int          CLOCK_HALF      = 10;
   localparam int          RESET_CYCLES    = 8;
   localparam int          RANDOM_PHASES   = 7;
   localparam int          PHASE_ITEMS     = 17;
   localparam int          PRESSURE_PHASE  = 3;
   localparam int          STEADY_PHASE    = 2;
   localparam int          LONG_HOLD       = 2000;
   localparam int          TAIL_CYCLES     = 500;
   localparam bit [63:0]   EXP_ALL_ONES    = {64{1'b1}};
   localparam bit [31:0]   OPERAND_ALL_ONES = {32{1'b1}};

   typedef struct {
      bit        is_write;
      bit [31:0] operand;
      bit [63:0] expo;
      bit        typed;
      bit [31:0] answer;
   } stimulus_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [mexp_pkg::REQ_TDATA_W-1:0] req_tdata;   // base_value, exponent
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [mexp_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // power_result
   logic                             csr_wr_en;
   logic [mexp_pkg::MODULUS_W-1:0]   csr_wr_data;

   bit [31:0] expected_powers[$];
   bit [31:0] modulus_setting;
   int        error_count;
   bit        steady;
   bit        hold_request;

   stimulus_row_type directed_rows[0:26] = '{
      '{1'b0, 32'd5,            64'd0,                 1'b1, 32'd1},
      '{1'b0, 32'd5,            64'd1,                 1'b1, 32'd0},
      '{1'b0, OPERAND_ALL_ONES, EXP_ALL_ONES,          1'b1, 32'd0},
      '{1'b1, OPERAND_ALL_ONES, 64'd0,                 1'b0, 32'd0},
      '{1'b0, 32'd0,            64'd0,                 1'b1, 32'd1},
      '{1'b0, 32'd0,            EXP_ALL_ONES,          1'b1, 32'd0},
      '{1'b0, 32'd1,            EXP_ALL_ONES,          1'b1, 32'd1},
      '{1'b0, OPERAND_ALL_ONES, 64'd1,                 1'b1, 32'd0},
      '{1'b0, 32'd2,            64'd31,                1'b1, 32'h8000_0000},
      '{1'b0, 32'hFFFF_FFFE,    64'd2,                 1'b1, 32'd1},
      '{1'b0, 32'h1234_5678,    64'h8000_0000_0000_0000, 1'b0, 32'd0},
      '{1'b0, 32'd3,            EXP_ALL_ONES,          1'b0, 32'd0},
      '{1'b1, 32'd0,            64'd0,                 1'b0, 32'd0},
      '{1'b0, 32'd2,            64'd32,                1'b1, 32'd0},
      '{1'b0, OPERAND_ALL_ONES, 64'd2,                 1'b1, 32'd1},
      '{1'b0, 32'd3,            64'd1,                 1'b1, 32'd3},
      '{1'b0, OPERAND_ALL_ONES, 64'd0,                 1'b1, 32'd1},
      '{1'b0, 32'hDEAD_BEEF,    EXP_ALL_ONES,          1'b0, 32'd0},
      '{1'b1, 32'd13,           64'd0,                 1'b0, 32'd0},
      '{1'b0, 32'd100,          64'd1,                 1'b1, 32'd9},
      '{1'b0, 32'd13,           64'd3,                 1'b1, 32'd0},
      '{1'b0, 32'd2,            64'd12,                1'b1, 32'd1},
      '{1'b0, OPERAND_ALL_ONES, EXP_ALL_ONES,          1'b0, 32'd0},
      '{1'b1, 32'd2,            64'd0,                 1'b0, 32'd0},
      '{1'b0, 32'd3,            64'h5555_5555_5555_5555, 1'b1, 32'd1},
      '{1'b0, 32'd0,            64'd0,                 1'b1, 32'd1},
      '{1'b0, 32'd0,            64'd7,                 1'b1, 32'd0}
   };

   modular_exponentiation i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic bit [63:0] mul_reduce(bit [63:0] x, bit [63:0] y, bit [31:0] m);
      bit [63:0] product;
      product = {32'd0, x[31:0]} * {32'd0, y[31:0]};
      // A zero modulus stands for two to the operand width.
      if (m == 32'd0) begin
         return {32'd0, product[31:0]};
      end
      return product % {32'd0, m};
   endfunction

   function automatic bit [31:0] power_mod(bit [31:0] base, bit [63:0] expo, bit [31:0] m);
      bit [63:0] acc;
      bit [63:0] square;
      bit [63:0] bits_left;
      acc = 64'd1;
      square = {32'd0, base};
      bits_left = expo;
      while (bits_left != 64'd0) begin
         if (bits_left[0]) begin
            acc = mul_reduce(acc, square, m);
         end
         square = mul_reduce(square, square, m);
         bits_left = bits_left >> 1;
      end
      return acc[31:0];
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic bit [63:0] random_exponent();
      case ($urandom_range(0, 7))
         0: return 64'($urandom_range(0, 3));
         1: return EXP_ALL_ONES;
         2, 3: return {$urandom, $urandom};
         default: return {$urandom, $urandom} >> $urandom_range(1, 63);
      endcase
   endfunction

   function automatic bit [31:0] random_base();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return $urandom_range(0, 15);
         default: return modulus_setting + $urandom_range(0, 2) - 32'd1;
      endcase
   endfunction

   task automatic report_mismatch(input string text);
      error_count++;
      $display("ERROR at %0t: %s", $time, text);
   endtask

   task automatic issue_request(input bit [31:0] base, input bit [63:0] expo,
                                input bit typed, input bit [31:0] answer);
      bit [31:0] predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {expo, base};
      do @(posedge clock); while (!req_tready);
      predicted = typed ? answer : power_mod(base, expo, modulus_setting);
      expected_powers = {expected_powers, predicted};
   endtask

   task automatic hold_requests(input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
   endtask

   task automatic program_modulus(input bit [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      modulus_setting = value;
   endtask

   initial begin : response_side
      int       stall_cycles;
      int       gap;
      bit [31:0] wanted;
      stall_cycles = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("unexpected result transfer 0x%08h", rsp_tdata));
            end else begin
               wanted = expected_powers.pop_front();
               if (rsp_tdata[31:0] !== wanted) begin
                  report_mismatch($sformatf("power_result 0x%08h, expected 0x%08h",
                                            rsp_tdata[31:0], wanted));
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_cycles = LONG_HOLD;
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            gap = idle_length();
            if (gap > 0) begin
               stall_cycles = gap - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
         @(posedge clock);
      end
   end

   initial begin : request_side
      bit [31:0] base;
      bit [63:0] expo;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      error_count  = 0;
      steady       = 1'b0;
      hold_request = 1'b0;
      modulus_setting = 32'd1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            drain_results();
            program_modulus(directed_rows[i].operand);
         end else begin
            issue_request(directed_rows[i].operand, directed_rows[i].expo,
                          directed_rows[i].typed, directed_rows[i].answer);
            hold_requests(idle_length());
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: program_modulus($urandom | 32'h8000_0000);
            1: program_modulus(OPERAND_ALL_ONES);
            2: program_modulus($urandom_range(2, 255));
            3: program_modulus($urandom_range(3, 65535));
            4: program_modulus(32'd1);
            5: program_modulus(32'd0);
            default: program_modulus($urandom);
         endcase
         steady = (phase == STEADY_PHASE);
         // Short exponents keep items quick so the output register fills during the hold.
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            base = random_base();
            if (phase == PRESSURE_PHASE) begin
               expo = 64'($urandom_range(1, 255));
            end else begin
               expo = random_exponent();
            end
            issue_request(base, expo, 1'b0, 32'd0);
            if (!steady && phase != PRESSURE_PHASE) begin
               hold_requests(idle_length());
            end
         end
      end

      drain_results();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/mexp_pkg.sv
hdl/mexp_modmul.sv
hdl/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
